[rtl/pfp_pkg.sv]
`timescale 1ns / 1ps

package pfp_pkg;

  // frame layout
  localparam int HEADER_LEN    = 8;
  localparam int LEN_POS       = 7;
  localparam int SUM_START_POS = 5;
  localparam int POLL_BYTES    = 5;

  // poll window width in bits
  localparam int WIN_W = 8 * POLL_BYTES;

  // field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 9;
  localparam int EV_W   = 3;
  localparam int CNT_W  = 32;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int HDR_W  = 40;

  // register indexes
  typedef enum logic [1:0] {
    REG_POLL_ENABLE = 2'd0,
    REG_START_BYTE  = 2'd1,
    REG_POLL_HEADER = 2'd2,
    REG_MAX_PAYLOAD = 2'd3
  } reg_idx_t;

  // register reset values
  localparam logic              RST_POLL_ENABLE = 1'b1;
  localparam logic [BYTE_W-1:0] RST_START_BYTE  = 8'd195;
  localparam logic [HDR_W-1:0]  RST_POLL_HEADER = 40'd837585782609;
  localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD = 8'd64;

  // result event codes
  typedef enum logic [EV_W-1:0] {
    EV_IGNORED    = 3'd0,
    EV_FRAME_BYTE = 3'd1,
    EV_FRAME_GOOD = 3'd2,
    EV_SUM_BAD    = 3'd3,
    EV_LEN_REJECT = 3'd4,
    EV_POLL       = 3'd5
  } event_t;

endpackage

[rtl/pfp_if.sv]
`timescale 1ns / 1ps

// received byte channel
interface pfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface pfp_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfp_pkg::BYTE_W-1:0]  data_byte;
  logic [pfp_pkg::POS_W-1:0]   frame_position;
  logic [pfp_pkg::EV_W-1:0]    event_res;
  logic [pfp_pkg::CNT_W-1:0]   discard_total;

  modport source (output valid, output data_byte, output frame_position,
                  output event_res, output discard_total, input ready);
  modport sink   (input valid, input data_byte, input frame_position,
                  input event_res, input discard_total, output ready);
endinterface

[rtl/poll_aware_frame_parser_top.sv]
`timescale 1ns / 1ps

// channel   | dir | payload                                          | handshake
// in_ch     | in  | rx_byte[7:0]                                     | valid/ready
// out_ch    | out | data_byte, frame_position, event_res, discard_total | valid/ready
// apb       | in  | paddr[4:0], pwdata/prdata[63:0], regs at 8*i     | psel/penable, pready=1
//
// one byte per cycle unless out_ch stalls: each byte is parsed by combinational
// logic from the parser state registers and is captured in the result register.
// the next byte is taken while a result waits, as long as out_ch takes it
// in the same cycle; a stalled result holds in_ch off.
// synchronous reset clears the parser state, the result valid and the
// registers to their defaults.

module poll_aware_frame_parser_top (
  input  logic                         clk,
  input  logic                         rst,
  pfp_in_if.sink                       in_ch,
  pfp_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [pfp_pkg::DATA_W-1:0]   pwdata,
  output logic [pfp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  // configuration registers
  logic                         poll_enable;
  logic [pfp_pkg::BYTE_W-1:0]   start_byte;
  logic [pfp_pkg::HDR_W-1:0]    poll_header;
  logic [pfp_pkg::BYTE_W-1:0]   max_payload;

  // parser state
  logic                         collecting;
  logic [pfp_pkg::POS_W-1:0]    byte_count;
  logic [pfp_pkg::POS_W-1:0]    expected_total;
  logic [pfp_pkg::BYTE_W-1:0]   sum_low;
  logic [pfp_pkg::BYTE_W-1:0]   sum_high;
  logic [pfp_pkg::BYTE_W-1:0]   first_check_byte;
  logic [pfp_pkg::BYTE_W-1:0]   held_len;
  logic [pfp_pkg::WIN_W-1:0]    poll_shift;
  logic [pfp_pkg::CNT_W-1:0]    discard_counter;

  logic                         collecting_next;
  logic [pfp_pkg::POS_W-1:0]    byte_count_next;
  logic [pfp_pkg::POS_W-1:0]    expected_total_next;
  logic [pfp_pkg::BYTE_W-1:0]   sum_low_next;
  logic [pfp_pkg::BYTE_W-1:0]   sum_high_next;
  logic [pfp_pkg::BYTE_W-1:0]   first_check_byte_next;
  logic [pfp_pkg::BYTE_W-1:0]   held_len_next;
  logic [pfp_pkg::WIN_W-1:0]    poll_shift_next;
  logic [pfp_pkg::CNT_W-1:0]    discard_counter_next;

  pfp_pkg::event_t              ev;
  logic [pfp_pkg::POS_W-1:0]    pos_res;
  logic [pfp_pkg::WIN_W-1:0]    header_win;
  logic                         cfg_wr;
  logic                         in_take;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_take = in_ch.valid && in_ch.ready;

  // the header is as wide as the poll window, so all of its bytes take part
  assign header_win = pfp_pkg::WIN_W'(64'(poll_header));

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_enable <= pfp_pkg::RST_POLL_ENABLE;
      start_byte  <= pfp_pkg::RST_START_BYTE;
      poll_header <= pfp_pkg::RST_POLL_HEADER;
      max_payload <= pfp_pkg::RST_MAX_PAYLOAD;
    end else if (cfg_wr) begin
      case (pfp_pkg::reg_idx_t'(paddr[4:3]))
        pfp_pkg::REG_POLL_ENABLE: poll_enable <= pwdata[0];
        pfp_pkg::REG_START_BYTE:  start_byte  <= pwdata[pfp_pkg::BYTE_W-1:0];
        pfp_pkg::REG_POLL_HEADER: poll_header <= pwdata[pfp_pkg::HDR_W-1:0];
        pfp_pkg::REG_MAX_PAYLOAD: max_payload <= pwdata[pfp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (pfp_pkg::reg_idx_t'(paddr[4:3]))
      pfp_pkg::REG_POLL_ENABLE: prdata = pfp_pkg::DATA_W'(poll_enable);
      pfp_pkg::REG_START_BYTE:  prdata = pfp_pkg::DATA_W'(start_byte);
      pfp_pkg::REG_POLL_HEADER: prdata = pfp_pkg::DATA_W'(poll_header);
      pfp_pkg::REG_MAX_PAYLOAD: prdata = pfp_pkg::DATA_W'(max_payload);
      default:                  prdata = '0;
    endcase
  end

  // per-byte parse
  always_comb begin
    logic                      done;
    logic [pfp_pkg::BYTE_W-1:0] b;
    logic [pfp_pkg::POS_W-1:0]  pos;
    logic [pfp_pkg::POS_W:0]    pos1;
    logic [pfp_pkg::POS_W:0]    pos2;
    logic [pfp_pkg::POS_W:0]    exp_w;

    b                     = in_ch.rx_byte;
    done                  = 1'b0;
    ev                    = pfp_pkg::EV_IGNORED;
    pos_res               = '0;
    pos                   = byte_count;
    pos1                  = '0;
    pos2                  = '0;
    exp_w                 = '0;
    collecting_next       = collecting;
    byte_count_next       = byte_count;
    expected_total_next   = expected_total;
    sum_low_next          = sum_low;
    sum_high_next         = sum_high;
    first_check_byte_next = first_check_byte;
    held_len_next         = held_len;
    poll_shift_next       = poll_shift;
    discard_counter_next  = discard_counter;

    // poll window
    if (poll_enable) begin
      poll_shift_next = pfp_pkg::WIN_W'({poll_shift, b});
      if (poll_shift_next == header_win) begin
        poll_shift_next = '0;
        collecting_next = 1'b0;
        ev              = pfp_pkg::EV_POLL;
        done            = 1'b1;
      end
    end

    // frame start
    if (!done && !collecting_next) begin
      if (b != start_byte) begin
        done = 1'b1;
      end else begin
        collecting_next       = 1'b1;
        byte_count_next       = '0;
        expected_total_next   = '0;
        sum_low_next          = '0;
        sum_high_next         = '0;
        first_check_byte_next = '0;
        held_len_next         = '0;
      end
    end

    // header and length
    if (!done) begin
      pos             = byte_count_next;
      pos1            = {1'b0, pos} + 10'd1;
      pos2            = {1'b0, pos} + 10'd2;
      byte_count_next = pos1[pfp_pkg::POS_W-1:0];
      pos_res         = pos;
      if (pos == pfp_pkg::POS_W'(pfp_pkg::LEN_POS)) begin
        held_len_next = b;
      end
      if (expected_total_next == '0 && pos1 == 10'(pfp_pkg::HEADER_LEN)) begin
        if (held_len_next > max_payload) begin
          collecting_next = 1'b0;
          ev              = pfp_pkg::EV_LEN_REJECT;
          done            = 1'b1;
        end else begin
          expected_total_next = pfp_pkg::POS_W'(pfp_pkg::HEADER_LEN)
                              + pfp_pkg::POS_W'(held_len_next) + 9'd2;
        end
      end
    end

    // checksum and frame end
    if (!done) begin
      exp_w = {1'b0, expected_total_next};
      if (pos >= pfp_pkg::POS_W'(pfp_pkg::SUM_START_POS)
          && (expected_total_next == '0 || pos2 < exp_w)) begin
        sum_low_next  = sum_low_next + b;
        sum_high_next = sum_high_next + sum_low_next;
      end
      if (expected_total_next != '0 && pos2 == exp_w) begin
        first_check_byte_next = b;
      end
      if (expected_total_next != '0 && pos1 >= exp_w) begin
        collecting_next = 1'b0;
        if (first_check_byte_next == sum_low_next && b == sum_high_next) begin
          ev = pfp_pkg::EV_FRAME_GOOD;
        end else begin
          if (discard_counter != '1) begin
            discard_counter_next = discard_counter + 32'd1;
          end
          ev = pfp_pkg::EV_SUM_BAD;
        end
      end else begin
        ev = pfp_pkg::EV_FRAME_BYTE;
      end
    end
  end

  // parser state update
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting       <= 1'b0;
      byte_count       <= '0;
      expected_total   <= '0;
      sum_low          <= '0;
      sum_high         <= '0;
      first_check_byte <= '0;
      held_len         <= '0;
      poll_shift       <= '0;
      discard_counter  <= '0;
    end else if (in_take) begin
      collecting       <= collecting_next;
      byte_count       <= byte_count_next;
      expected_total   <= expected_total_next;
      sum_low          <= sum_low_next;
      sum_high         <= sum_high_next;
      first_check_byte <= first_check_byte_next;
      held_len         <= held_len_next;
      poll_shift       <= poll_shift_next;
      discard_counter  <= discard_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_take) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_ch.data_byte      <= in_ch.rx_byte;
      out_ch.frame_position <= pos_res;
      out_ch.event_res      <= ev;
      out_ch.discard_total  <= discard_counter_next;
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [pfp_pkg::BYTE_W-1:0] data_byte;
    logic [pfp_pkg::POS_W-1:0]  frame_position;
    pfp_pkg::event_t            event_res;
    logic [pfp_pkg::CNT_W-1:0]  discard_total;
  } parse_result_t;

  // frame parser prediction and result checking
  class frame_scoreboard;
    logic                       poll_enable;
    logic [pfp_pkg::BYTE_W-1:0] start_byte;
    logic [pfp_pkg::HDR_W-1:0]  poll_header;
    logic [pfp_pkg::BYTE_W-1:0] max_payload;

    bit                         in_frame;
    logic [pfp_pkg::POS_W-1:0]  byte_count;
    logic [pfp_pkg::POS_W-1:0]  expected_total;
    logic [pfp_pkg::BYTE_W-1:0] sum_low;
    logic [pfp_pkg::BYTE_W-1:0] sum_high;
    logic [pfp_pkg::BYTE_W-1:0] first_check;
    logic [pfp_pkg::BYTE_W-1:0] held_len;
    logic [pfp_pkg::WIN_W-1:0]  poll_window;
    logic [pfp_pkg::CNT_W-1:0]  discard_count;

    parse_result_t              pending_results[$];
    int                         errors;

    function new();
      poll_enable    = pfp_pkg::RST_POLL_ENABLE;
      start_byte     = pfp_pkg::RST_START_BYTE;
      poll_header    = pfp_pkg::RST_POLL_HEADER;
      max_payload    = pfp_pkg::RST_MAX_PAYLOAD;
      in_frame       = 1'b0;
      byte_count     = '0;
      expected_total = '0;
      sum_low        = '0;
      sum_high       = '0;
      first_check    = '0;
      held_len       = '0;
      poll_window    = '0;
      discard_count  = '0;
      errors         = 0;
    endfunction

    function void write_reg(pfp_pkg::reg_idx_t idx, logic [pfp_pkg::DATA_W-1:0] val);
      case (idx)
        pfp_pkg::REG_POLL_ENABLE: poll_enable = val[0];
        pfp_pkg::REG_START_BYTE:  start_byte  = val[pfp_pkg::BYTE_W-1:0];
        pfp_pkg::REG_POLL_HEADER: poll_header = val[pfp_pkg::HDR_W-1:0];
        pfp_pkg::REG_MAX_PAYLOAD: max_payload = val[pfp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    // one received byte through the parser state
    function parse_result_t parse_byte(logic [pfp_pkg::BYTE_W-1:0] b);
      parse_result_t r;
      int pos;
      r.data_byte      = b;
      r.frame_position = '0;
      r.event_res      = pfp_pkg::EV_IGNORED;
      r.discard_total  = discard_count;

      // poll window match abandons any frame
      if (poll_enable) begin
        poll_window = {poll_window[pfp_pkg::WIN_W-9:0], b};
        if (poll_window == poll_header[pfp_pkg::WIN_W-1:0]) begin
          poll_window = '0;
          in_frame    = 1'b0;
          r.event_res = pfp_pkg::EV_POLL;
          return r;
        end
      end

      if (!in_frame) begin
        if (b != start_byte) return r;
        in_frame       = 1'b1;
        byte_count     = '0;
        expected_total = '0;
        sum_low        = '0;
        sum_high       = '0;
        first_check    = '0;
        held_len       = '0;
      end

      pos = int'(byte_count);
      byte_count = pfp_pkg::POS_W'(pos + 1);
      r.frame_position = pfp_pkg::POS_W'(pos);
      if (pos == pfp_pkg::LEN_POS) held_len = b;

      // header complete: length check and frame size
      if (expected_total == 0 && pos + 1 == pfp_pkg::HEADER_LEN) begin
        if (held_len > max_payload) begin
          in_frame    = 1'b0;
          r.event_res = pfp_pkg::EV_LEN_REJECT;
          return r;
        end
        expected_total = pfp_pkg::POS_W'(pfp_pkg::HEADER_LEN + int'(held_len) + 2);
      end

      // running two-sum checksum
      if (pos >= pfp_pkg::SUM_START_POS &&
          (expected_total == 0 || pos + 2 < int'(expected_total))) begin
        sum_low  = sum_low + b;
        sum_high = sum_high + sum_low;
      end
      if (expected_total != 0 && pos + 2 == int'(expected_total)) first_check = b;

      // last byte of the frame
      if (expected_total != 0 && pos + 1 >= int'(expected_total)) begin
        in_frame = 1'b0;
        if (first_check == sum_low && b == sum_high) begin
          r.event_res = pfp_pkg::EV_FRAME_GOOD;
        end else begin
          if (discard_count != '1) discard_count = discard_count + 1'b1;
          r.event_res = pfp_pkg::EV_SUM_BAD;
        end
      end else begin
        r.event_res = pfp_pkg::EV_FRAME_BYTE;
      end
      r.discard_total = discard_count;
      return r;
    endfunction

    function void note_byte(logic [pfp_pkg::BYTE_W-1:0] b);
      pending_results.insert(pending_results.size(), parse_byte(b));
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch: %s", what);
    endtask

    task check_result(parse_result_t got);
      parse_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with no byte pending, data_byte %02h", got.data_byte));
        return;
      end
      want = pending_results.pop_front();
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
      if (got.frame_position !== want.frame_position)
        report($sformatf("frame_position %0d, want %0d (byte %02h)",
                         got.frame_position, want.frame_position, want.data_byte));
      if (got.event_res !== want.event_res)
        report($sformatf("event_res %0d, want %0d (byte %02h pos %0d)",
                         got.event_res, want.event_res, want.data_byte,
                         want.frame_position));
      if (got.discard_total !== want.discard_total)
        report($sformatf("discard_total %0d, want %0d",
                         got.discard_total, want.discard_total));
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [pfp_pkg::ADDR_W-1:0] paddr;
  logic [pfp_pkg::DATA_W-1:0] pwdata;
  logic [pfp_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  pfp_in_if  in_ch();
  pfp_out_if out_ch();

  poll_aware_frame_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_scoreboard            sb = new();
  logic [pfp_pkg::BYTE_W-1:0] tx_q[$];
  int                         burst_left = 0;
  int                         quiet_cycles = 0;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver stall pattern: free running, random, periodic, long stalls
  int stall_mode = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_val   = 1'b1;
  int cyc        = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end
    stall_left--;
    cyc++;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ((cyc % 5) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_val  = ~hold_val;
          hold_left = $urandom_range(1, 20);
        end
        hold_left--;
        out_ch.ready <= hold_val;
      end
    endcase
  end

  // result monitor and watchdog; values are stable at the falling edge
  always @(negedge clk) begin
    parse_result_t got;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.data_byte      = out_ch.data_byte;
        got.frame_position = out_ch.frame_position;
        got.event_res      = pfp_pkg::event_t'(out_ch.event_res);
        got.discard_total  = out_ch.discard_total;
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // append one byte to the transmit queue
  function automatic void add_tx_byte(logic [pfp_pkg::BYTE_W-1:0] b);
    tx_q.insert(tx_q.size(), b);
  endfunction

  // one byte on the input channel, with sender bursts and gaps
  task automatic send_byte(logic [pfp_pkg::BYTE_W-1:0] b);
    bit took;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    sb.note_byte(b);
  endtask

  task automatic send_queued();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // stop sending and wait for every pending result
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(pfp_pkg::reg_idx_t idx, logic [pfp_pkg::DATA_W-1:0] val);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pfp_pkg::ADDR_W'(int'(idx) * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic pe, logic [pfp_pkg::BYTE_W-1:0] st,
                               logic [pfp_pkg::HDR_W-1:0] hdr,
                               logic [pfp_pkg::BYTE_W-1:0] mp);
    reg_write(pfp_pkg::REG_POLL_ENABLE, pfp_pkg::DATA_W'(pe));
    reg_write(pfp_pkg::REG_START_BYTE, pfp_pkg::DATA_W'(st));
    reg_write(pfp_pkg::REG_POLL_HEADER, pfp_pkg::DATA_W'(hdr));
    reg_write(pfp_pkg::REG_MAX_PAYLOAD, pfp_pkg::DATA_W'(mp));
  endtask

  // frame header: start byte, random header bytes, length byte
  function automatic void add_header(int len);
    for (int i = 0; i < pfp_pkg::HEADER_LEN; i++) begin
      if (i == 0)                     add_tx_byte(sb.start_byte);
      else if (i == pfp_pkg::LEN_POS) add_tx_byte(pfp_pkg::BYTE_W'(len));
      else                            add_tx_byte(pfp_pkg::BYTE_W'($urandom_range(0, 255)));
    end
  endfunction

  // whole frame with check bytes, optionally with one check bit flipped
  function automatic void add_frame(int len, bit corrupt);
    logic [pfp_pkg::BYTE_W-1:0] lo;
    logic [pfp_pkg::BYTE_W-1:0] hi;
    int first;
    first = tx_q.size();
    add_header(len);
    for (int i = 0; i < len; i++) add_tx_byte(pfp_pkg::BYTE_W'($urandom_range(0, 255)));
    lo = '0;
    hi = '0;
    for (int i = first + pfp_pkg::SUM_START_POS; i < tx_q.size(); i++) begin
      lo = lo + tx_q[i];
      hi = hi + lo;
    end
    if (corrupt) begin
      if ($urandom_range(0, 1)) lo = lo ^ (8'h1 << $urandom_range(0, 7));
      else                      hi = hi ^ (8'h1 << $urandom_range(0, 7));
    end
    add_tx_byte(lo);
    add_tx_byte(hi);
  endfunction

  function automatic void add_poll();
    for (int i = pfp_pkg::POLL_BYTES - 1; i >= 0; i--) add_tx_byte(sb.poll_header[8*i +: 8]);
  endfunction

  // mostly short payloads, now and then the largest allowed
  function automatic int pick_len();
    int m;
    int r;
    m = int'(sb.max_payload);
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, (m < 12) ? m : 12);
    if (r < 95) return $urandom_range(0, (m < 64) ? m : 64);
    return m;
  endfunction

  task automatic random_traffic(int n_items);
    int sent;
    int k;
    int n;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        add_frame(pick_len(), 1'b0);
      end else if (k < 63) begin
        add_frame(pick_len(), 1'b1);
      end else if (k < 71) begin
        // oversize length byte
        if (sb.max_payload != 8'hFF) add_header($urandom_range(int'(sb.max_payload) + 1, 255));
        else add_frame(pick_len(), 1'b0);
      end else if (k < 81) begin
        add_poll();
      end else if (k < 90) begin
        // frame cut short, sometimes by a poll
        add_tx_byte(sb.start_byte);
        n = $urandom_range(0, pfp_pkg::HEADER_LEN + 4);
        for (int i = 0; i < n; i++) add_tx_byte(pfp_pkg::BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) add_poll();
      end else begin
        // line noise, not counted
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) add_tx_byte(pfp_pkg::BYTE_W'($urandom_range(0, 255)));
        sent -= n;
      end
      sent += tx_q.size();
      send_queued();
    end
  endtask

  // main sequence
  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte extremes, poll, length reject, empty good frame
    add_tx_byte(8'h00);
    add_tx_byte(8'hFF);
    add_poll();
    add_header(255);
    add_frame(0, 1'b0);
    send_queued();
    random_traffic(150);
    wait_results_done();

    // low extremes: zero header, zero start, zero payload limit
    apply_setting(1'b1, 8'h00, '0, 8'h00);
    random_traffic(170);
    wait_results_done();

    // high extremes with poll watching off
    apply_setting(1'b0, 8'hFF, '1, 8'hFF);
    random_traffic(170);
    wait_results_done();

    // random start and header, modest payload limit
    apply_setting(1'b1, pfp_pkg::BYTE_W'($urandom), {8'($urandom), 32'($urandom)},
                  pfp_pkg::BYTE_W'($urandom_range(1, 40)));
    random_traffic(170);
    wait_results_done();

    // everything random
    apply_setting(1'($urandom_range(0, 1)), pfp_pkg::BYTE_W'($urandom),
                  {8'($urandom), 32'($urandom)}, pfp_pkg::BYTE_W'($urandom_range(0, 255)));
    random_traffic(170);
    wait_results_done();

    // back to the reset defaults
    apply_setting(pfp_pkg::RST_POLL_ENABLE, pfp_pkg::RST_START_BYTE,
                  pfp_pkg::RST_POLL_HEADER, pfp_pkg::RST_MAX_PAYLOAD);
    random_traffic(170);
    wait_results_done();
    repeat (8) @(posedge clk);

    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
